FILE: src/lcd_address_window_writer_core_macros.svh
// Assertion helpers for the RTL of the address window writer.
`ifndef LCD_ADDRESS_WINDOW_WRITER_CORE_MACROS_SVH
`define LCD_ADDRESS_WINDOW_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LAWC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LAWC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lawc_pkg.sv
package lawc_pkg;

	// Panel geometry.
	localparam int PANEL_COLUMNS = 240;
	localparam int PANEL_ROWS    = 320;

	localparam int COL_W   = $clog2(PANEL_COLUMNS);
	localparam int ROW_W   = $clog2(PANEL_ROWS);
	localparam int COLOR_W = 16;
	localparam int BUS_W   = 16;
	localparam int CODE_W  = 8;
	localparam int CFG_INDEX_W = 2;

	// Result item packing: column, row, color from the lowest bit up.
	localparam int OUT_BITS    = COL_W + ROW_W + COLOR_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Default command codes.
	localparam logic [CODE_W-1:0] DEF_COLUMN_SET_CODE   = 8'h2A;
	localparam logic [CODE_W-1:0] DEF_ROW_SET_CODE      = 8'h2B;
	localparam logic [CODE_W-1:0] DEF_MEMORY_WRITE_CODE = 8'h2C;
	localparam logic [CODE_W-1:0] NO_COMMAND            = 8'h00;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COLUMN_SET   = 2'd0,
		REG_ROW_SET      = 2'd1,
		REG_MEMORY_WRITE = 2'd2
	} cfg_reg_t;

	// Parameter byte position within a window command.
	localparam int PARAM_CNT_W = 3;
	localparam logic [PARAM_CNT_W-1:0] PARAM_START_HI = 3'd0;
	localparam logic [PARAM_CNT_W-1:0] PARAM_START_LO = 3'd1;
	localparam logic [PARAM_CNT_W-1:0] PARAM_END_HI   = 3'd2;
	localparam logic [PARAM_CNT_W-1:0] PARAM_END_LO   = 3'd3;
	localparam logic [PARAM_CNT_W-1:0] PARAM_DONE     = 3'd4;

	// Input item kind carried on tuser.
	localparam logic MODE_COMMAND = 1'b0;
	localparam logic MODE_DATA    = 1'b1;

endpackage

FILE: src/lcd_address_window_writer_core.sv
// Panel side of a 16-bit command/data bus with a column/row address window. Input items carry
// the command/data flag on s_axis_tuser and the bus word on s_axis_tdata. A command item
// selects the active command from its low byte; the column-set and row-set commands then take
// four parameter bytes (start high, start low, end high, end low), each value clamped to the
// panel, the start taking effect on its second byte and the end on its fourth. The
// memory-write command moves the cursor to the window start, and every following data item
// becomes one result item: the pixel's column, row and color on m_axis_tdata, with
// m_axis_tlast set on the window's last pixel (end column and end row). The cursor advances
// column first and wraps inside the window. Other commands and their parameters produce no
// result. The block takes one item every clock cycle: all decoding and the cursor step are a
// single compare-and-increment from the state registers into one output register, and that
// register is refilled in the same cycle it is taken, so the only stall comes from the
// downstream side holding m_axis_tready low. Command codes must be written through the cfg port
// while the block is idle; the block itself does not enforce this.
`include "lcd_address_window_writer_core_macros.svh"

module lcd_address_window_writer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [lawc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lawc_pkg::CODE_W-1:0]         cfg_data,
	// Input items
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lawc_pkg::BUS_W-1:0]          s_axis_tdata,  // bus_value
	input  logic                                s_axis_tuser,  // mode
	// Result items
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [lawc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // pixel_column, pixel_row,
	                                                           // pixel_color, zero fill
	output logic                                m_axis_tlast   // window_done
);
	import lawc_pkg::*;

	// Command code registers.
	logic [CODE_W-1:0] column_set_code_q;
	logic [CODE_W-1:0] row_set_code_q;
	logic [CODE_W-1:0] memory_write_code_q;

	// Decoder and window state.
	logic [CODE_W-1:0]      active_cmd_q;
	logic [PARAM_CNT_W-1:0] param_cnt_q;
	logic [7:0]             held_byte_q;
	logic [COL_W-1:0]       col_start_q;
	logic [COL_W-1:0]       col_end_q;
	logic [ROW_W-1:0]       row_start_q;
	logic [ROW_W-1:0]       row_end_q;
	logic [COL_W-1:0]       cursor_col_q;
	logic [ROW_W-1:0]       cursor_row_q;
	logic                   writing_q;

	// Output register.
	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_data_q;
	logic                   out_last_q;

	logic              in_acc;
	logic              load_out;
	logic [7:0]        low_byte;
	logic              is_mem_write;
	logic              col_cmd_active;
	logic              row_cmd_active;
	logic [15:0]       param_value;
	logic [COL_W-1:0]  param_col;
	logic [ROW_W-1:0]  param_row;
	logic              col_last;
	logic              row_last;

	// The output register can take a new result whenever it is empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_out      = in_acc && (s_axis_tuser == MODE_DATA) && writing_q;

	assign low_byte = s_axis_tdata[7:0];

	// On colliding codes the column-set match wins, then row-set, then memory-write.
	assign is_mem_write = (low_byte != column_set_code_q) && (low_byte != row_set_code_q)
		&& (low_byte == memory_write_code_q);
	assign col_cmd_active = (active_cmd_q == column_set_code_q);
	assign row_cmd_active = !col_cmd_active && (active_cmd_q == row_set_code_q);

	// A full 16-bit start or end value, clamped to the last column or row.
	assign param_value = {held_byte_q, low_byte};
	assign param_col = (param_value > 16'(PANEL_COLUMNS - 1)) ? COL_W'(PANEL_COLUMNS - 1)
		: param_value[COL_W-1:0];
	assign param_row = (param_value > 16'(PANEL_ROWS - 1)) ? ROW_W'(PANEL_ROWS - 1)
		: param_value[ROW_W-1:0];

	// Greater-or-equal so that a start past the end wraps at once on that axis.
	assign col_last = (cursor_col_q >= col_end_q);
	assign row_last = (cursor_row_q >= row_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_set_code_q   <= DEF_COLUMN_SET_CODE;
			row_set_code_q      <= DEF_ROW_SET_CODE;
			memory_write_code_q <= DEF_MEMORY_WRITE_CODE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COLUMN_SET:   column_set_code_q   <= cfg_data;
				REG_ROW_SET:      row_set_code_q      <= cfg_data;
				REG_MEMORY_WRITE: memory_write_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cmd_q <= NO_COMMAND;
			param_cnt_q  <= PARAM_START_HI;
			held_byte_q  <= '0;
			col_start_q  <= '0;
			col_end_q    <= COL_W'(PANEL_COLUMNS - 1);
			row_start_q  <= '0;
			row_end_q    <= ROW_W'(PANEL_ROWS - 1);
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			writing_q    <= 1'b0;
		end else if (in_acc) begin
			if (s_axis_tuser == MODE_COMMAND) begin
				active_cmd_q <= low_byte;
				param_cnt_q  <= PARAM_START_HI;
				writing_q    <= is_mem_write;
				if (is_mem_write) begin
					cursor_col_q <= col_start_q;
					cursor_row_q <= row_start_q;
				end
			end else if (writing_q) begin
				if (col_last) begin
					cursor_col_q <= col_start_q;
					cursor_row_q <= row_last ? row_start_q : cursor_row_q + 1'b1;
				end else begin
					cursor_col_q <= cursor_col_q + 1'b1;
				end
			end else if (col_cmd_active || row_cmd_active) begin
				unique case (param_cnt_q)
					PARAM_START_HI, PARAM_END_HI: held_byte_q <= low_byte;
					PARAM_START_LO: begin
						if (col_cmd_active) col_start_q <= param_col;
						else                row_start_q <= param_row;
					end
					PARAM_END_LO: begin
						if (col_cmd_active) col_end_q <= param_col;
						else                row_end_q <= param_row;
					end
					default: ;
				endcase
				// Bytes after the fourth are ignored; the count stops there.
				if (param_cnt_q < PARAM_DONE)
					param_cnt_q <= param_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {s_axis_tdata, cursor_row_q, cursor_col_q};
			out_last_q <= col_last && row_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);
	assign m_axis_tlast  = out_last_q;

	`LAWC_ASSERT_NEXT(a_cmd_no_result,
		in_acc && (s_axis_tuser == MODE_COMMAND),
		m_axis_tvalid == $past(m_axis_tvalid && !m_axis_tready),
		"command item produced a result")
	`LAWC_ASSERT_NOW(a_window_in_panel,
		1'b1,
		(col_end_q <= COL_W'(PANEL_COLUMNS - 1)) && (row_end_q <= ROW_W'(PANEL_ROWS - 1))
		&& (col_start_q <= COL_W'(PANEL_COLUMNS - 1))
		&& (row_start_q <= ROW_W'(PANEL_ROWS - 1)),
		"window bound beyond panel")
	`LAWC_ASSERT_NOW(a_cursor_in_panel,
		writing_q,
		(cursor_col_q <= COL_W'(PANEL_COLUMNS - 1)) && (cursor_row_q <= ROW_W'(PANEL_ROWS - 1)),
		"cursor beyond panel")
	`LAWC_ASSERT_NOW(a_param_cnt_range,
		1'b1,
		param_cnt_q <= PARAM_DONE,
		"parameter count out of range")

endmodule
